/* rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes, constants and the queued item type of the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   // result width checked for overflow after reduction
   localparam int WIDTH = 32;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_NEG = 3'd4;
   localparam logic [2:0] OP_EQ  = 3'd5;
   localparam logic [2:0] OP_LT  = 3'd6;
   localparam logic [2:0] OP_NONE = 3'd7;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZDEN = 2'd1;
   localparam logic [1:0] ST_DIVZ = 2'd2;
   localparam logic [1:0] ST_OVF  = 2'd3;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // one classified item on its way from front to back
   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] an;
      logic [31:0] ad;
      logic [31:0] bn;
      logic [31:0] bd;
      logic        aneg;
      logic        bneg;
      logic        bneg_as;   // sign of b as it enters add or subtract
      logic        early;     // result known without arithmetic
      logic [1:0]  early_st;
   } rau_item_type;

endpackage

/* rtl/rau_front.sv */
// ----------------------------------------------------------------------------
// rau_front
// Accepts request beats, takes magnitudes and signs, and flags errors early.
// ----------------------------------------------------------------------------
module rau_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_type,
   input  logic signed [31:0]    req_a_num,
   input  logic signed [31:0]    req_a_den,
   input  logic signed [31:0]    req_b_num,
   input  logic signed [31:0]    req_b_den,
   input  logic                  q_full,
   output logic                  q_push,
   output rau_pkg::rau_item_type q_item
);

   logic [31:0] an, ad, bn, bd;
   logic        aneg, bneg;

   assign an = req_a_num[31] ? (~req_a_num + 32'd1) : req_a_num;
   assign ad = req_a_den[31] ? (~req_a_den + 32'd1) : req_a_den;
   assign bn = req_b_num[31] ? (~req_b_num + 32'd1) : req_b_num;
   assign bd = req_b_den[31] ? (~req_b_den + 32'd1) : req_b_den;
   assign aneg = (an != 32'd0) && (req_a_num[31] != req_a_den[31]);
   assign bneg = (bn != 32'd0) && (req_b_num[31] != req_b_den[31]);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.op       = req_type;
      q_item.an       = an;
      q_item.ad       = ad;
      q_item.bn       = bn;
      q_item.bd       = bd;
      q_item.aneg     = aneg;
      q_item.bneg     = bneg;
      q_item.bneg_as  = (req_type == rau_pkg::OP_SUB) ? (bn != 32'd0 && !bneg) : bneg;
      q_item.early    = 1'b1;
      q_item.early_st = rau_pkg::ST_OK;
      if (req_type == rau_pkg::OP_NONE) begin
         q_item.early_st = rau_pkg::ST_OK;
      end else if (ad == 32'd0) begin
         q_item.early_st = rau_pkg::ST_ZDEN;
      end else if (req_type != rau_pkg::OP_NEG && bd == 32'd0) begin
         q_item.early_st = rau_pkg::ST_ZDEN;
      end else if (req_type == rau_pkg::OP_DIV && bn == 32'd0) begin
         q_item.early_st = rau_pkg::ST_DIVZ;
      end else begin
         q_item.early = 1'b0;
      end
   end

endmodule

/* rtl/rau_queue.sv */
// ----------------------------------------------------------------------------
// rau_queue
// Short FIFO between the front and the back of the unit.
// ----------------------------------------------------------------------------
module rau_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rau_pkg::rau_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output rau_pkg::rau_item_type pop_item,
   output logic                  not_empty
);

   rau_pkg::rau_item_type mem [rau_pkg::QDEPTH];
   logic [rau_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [rau_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == rau_pkg::QCNT_W'(rau_pkg::QDEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_item  = mem[rd_ff];

   function automatic logic [rau_pkg::QPTR_W-1:0] bump(input logic [rau_pkg::QPTR_W-1:0] p);
      bump = (p == rau_pkg::QPTR_W'(rau_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_in  = push ? bump(wr_ff) : wr_ff;
      rd_in  = pop ? bump(rd_ff) : rd_ff;
      cnt_in = cnt_ff + rau_pkg::QCNT_W'(push) - rau_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/rau_core.sv */
// ----------------------------------------------------------------------------
// rau_core
// Sequencer with one multiplier, a binary gcd and a restoring divider.
// ----------------------------------------------------------------------------
module rau_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  rau_pkg::rau_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_res_num,
   output logic [30:0]           rsp_res_den,
   output logic                  rsp_cmp_true,
   output logic [1:0]            rsp_status
);

   localparam logic [64:0] HALF  = 65'd1 << (rau_pkg::WIDTH - 1);
   localparam logic [64:0] LIMIT = HALF - 65'd1;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_GCD   = 10'b0000000010,
      S_DIV   = 10'b0000000100,
      S_MUL1  = 10'b0000001000,
      S_MUL2  = 10'b0000010000,
      S_MUL3  = 10'b0000100000,
      S_COMB  = 10'b0001000000,
      S_CHECK = 10'b0010000000,
      S_CMP   = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   localparam logic [1:0] D_Q1  = 2'd0;
   localparam logic [1:0] D_Q2  = 2'd1;
   localparam logic [1:0] D_NUM = 2'd2;
   localparam logic [1:0] D_DEN = 2'd3;

   state_type   state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [31:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic        aneg_ff, aneg_in, bneg_ff, bneg_in, bnas_ff, bnas_in;
   logic [31:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [63:0] num_ff, num_in, den_ff, den_in, aux_ff, aux_in;
   logic        sign_ff, sign_in, reduce_ff, reduce_in;
   logic [63:0] gx_ff, gx_in, gy_ff, gy_in, g_ff, g_in;
   logic [5:0]  gk_ff, gk_in, cnt_ff, cnt_in;
   logic [63:0] dvd_ff, dvd_in, rem_ff, rem_in;
   logic [1:0]  dsel_ff, dsel_in;
   logic [31:0] rnum_ff, rnum_in;
   logic [30:0] rden_ff, rden_in;
   logic        rcmp_ff, rcmp_in;
   logic [1:0]  rst_ff, rst_in;

   logic [31:0] m_a, m_b;
   logic [63:0] prod;
   logic [64:0] sh, diff;
   logic        ge;
   logic [63:0] dvd_nx, rem_nx, gval, comb_n, negn, lhs, rhs, d_eff;
   logic        comb_s, neg_eff, ovf;

   assign prod = m_a * m_b;

   // one restoring divide step
   assign sh     = {rem_ff, dvd_ff[63]};
   assign diff   = sh - {1'b0, g_ff};
   assign ge     = (sh >= {1'b0, g_ff});
   assign rem_nx = ge ? diff[63:0] : sh[63:0];
   assign dvd_nx = {dvd_ff[62:0], ge};

   assign gval  = (gx_ff | gy_ff) << gk_ff;
   assign negn  = 64'd0 - num_ff;
   assign lhs   = aneg_ff ? (64'd0 - num_ff) : num_ff;
   assign rhs   = bneg_ff ? (64'd0 - den_ff) : den_ff;
   assign d_eff = (num_ff == 64'd0) ? 64'd1 : den_ff;
   assign neg_eff = sign_ff && (num_ff != 64'd0);
   assign ovf = ({1'b0, d_eff} > LIMIT) ||
                (neg_eff ? ({1'b0, num_ff} > HALF) : ({1'b0, num_ff} > LIMIT));

   always_comb begin
      if (aneg_ff == bnas_ff) begin
         comb_n = num_ff + aux_ff;
         comb_s = aneg_ff;
      end else if (num_ff >= aux_ff) begin
         comb_n = num_ff - aux_ff;
         comb_s = aneg_ff;
      end else begin
         comb_n = aux_ff - num_ff;
         comb_s = bnas_ff;
      end
   end

   always_comb begin
      m_a = an_ff;
      m_b = q1_ff;
      if (state_ff == S_MUL1) begin
         m_a = an_ff;
         if (op_ff == rau_pkg::OP_ADD || op_ff == rau_pkg::OP_SUB) begin
            m_b = q1_ff;
         end else if (op_ff == rau_pkg::OP_MUL) begin
            m_b = bn_ff;
         end else begin
            m_b = bd_ff;
         end
      end else if (state_ff == S_MUL2) begin
         m_a = ad_ff;
         if (op_ff == rau_pkg::OP_ADD || op_ff == rau_pkg::OP_SUB) begin
            m_b = q1_ff;
         end else if (op_ff == rau_pkg::OP_MUL) begin
            m_b = bd_ff;
         end else begin
            m_b = bn_ff;
         end
      end else begin
         m_a = bn_ff;
         m_b = q2_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      aneg_in = aneg_ff; bneg_in = bneg_ff; bnas_in = bnas_ff;
      q1_in = q1_ff; q2_in = q2_ff;
      num_in = num_ff; den_in = den_ff; aux_in = aux_ff;
      sign_in = sign_ff; reduce_in = reduce_ff;
      gx_in = gx_ff; gy_in = gy_ff; gk_in = gk_ff; g_in = g_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; cnt_in = cnt_ff; dsel_in = dsel_ff;
      rnum_in = rnum_ff; rden_in = rden_ff; rcmp_in = rcmp_ff; rst_in = rst_ff;
      q_pop = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               op_in   = q_item.op;
               an_in   = q_item.an;
               ad_in   = q_item.ad;
               bn_in   = q_item.bn;
               bd_in   = q_item.bd;
               aneg_in = q_item.aneg;
               bneg_in = q_item.bneg;
               bnas_in = q_item.bneg_as;
               sign_in = q_item.aneg != q_item.bneg;
               gk_in   = '0;
               rnum_in = '0;
               rden_in = '0;
               rcmp_in = 1'b0;
               rst_in  = q_item.early_st;
               if (q_item.early) begin
                  state_in = S_OUT;
               end else begin
                  unique case (q_item.op)
                     rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                        gx_in     = {32'd0, q_item.ad};
                        gy_in     = {32'd0, q_item.bd};
                        reduce_in = 1'b0;
                        state_in  = S_GCD;
                     end
                     rau_pkg::OP_NEG: begin
                        num_in    = {32'd0, q_item.an};
                        den_in    = {32'd0, q_item.ad};
                        sign_in   = !q_item.aneg;
                        gx_in     = {32'd0, q_item.an};
                        gy_in     = {32'd0, q_item.ad};
                        reduce_in = 1'b1;
                        state_in  = S_GCD;
                     end
                     default: begin
                        state_in = S_MUL1;
                     end
                  endcase
               end
            end
         end
         S_GCD: begin
            if (gx_ff == 64'd0 || gy_ff == 64'd0) begin
               g_in     = gval;
               rem_in   = '0;
               cnt_in   = '0;
               dvd_in   = reduce_ff ? num_ff : {32'd0, bd_ff};
               dsel_in  = reduce_ff ? D_NUM : D_Q1;
               state_in = S_DIV;
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               gk_in = gk_ff + 6'd1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff >= gy_ff) begin
               gx_in = gx_ff - gy_ff;
            end else begin
               gy_in = gy_ff - gx_ff;
            end
         end
         S_DIV: begin
            dvd_in = dvd_nx;
            rem_in = rem_nx;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               // quotient done: route it and start the next divide if any
               rem_in = '0;
               cnt_in = '0;
               case (dsel_ff)
                  D_Q1: begin
                     q1_in   = dvd_nx[31:0];
                     dvd_in  = {32'd0, ad_ff};
                     dsel_in = D_Q2;
                  end
                  D_Q2: begin
                     q2_in    = dvd_nx[31:0];
                     state_in = S_MUL1;
                  end
                  D_NUM: begin
                     num_in  = dvd_nx;
                     dvd_in  = den_ff;
                     dsel_in = D_DEN;
                  end
                  default: begin
                     den_in   = dvd_nx;
                     state_in = S_CHECK;
                  end
               endcase
            end
         end
         S_MUL1: begin
            num_in   = prod;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            den_in = prod;
            if (op_ff == rau_pkg::OP_ADD || op_ff == rau_pkg::OP_SUB) begin
               state_in = S_MUL3;
            end else if (op_ff == rau_pkg::OP_EQ || op_ff == rau_pkg::OP_LT) begin
               state_in = S_CMP;
            end else begin
               gx_in     = num_ff;
               gy_in     = prod;
               reduce_in = 1'b1;
               state_in  = S_GCD;
            end
         end
         S_MUL3: begin
            aux_in   = prod;
            state_in = S_COMB;
         end
         S_COMB: begin
            num_in    = comb_n;
            sign_in   = comb_s;
            gx_in     = comb_n;
            gy_in     = den_ff;
            gk_in     = '0;
            reduce_in = 1'b1;
            state_in  = S_GCD;
         end
         S_CHECK: begin
            if (ovf) begin
               rst_in = rau_pkg::ST_OVF;
            end else begin
               rnum_in = neg_eff ? negn[31:0] : num_ff[31:0];
               rden_in = d_eff[30:0];
            end
            state_in = S_OUT;
         end
         S_CMP: begin
            rcmp_in  = (op_ff == rau_pkg::OP_EQ) ? (lhs == rhs)
                                                  : ($signed(lhs) < $signed(rhs));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      aneg_ff <= aneg_in; bneg_ff <= bneg_in; bnas_ff <= bnas_in;
      q1_ff <= q1_in; q2_ff <= q2_in;
      num_ff <= num_in; den_ff <= den_in; aux_ff <= aux_in;
      sign_ff <= sign_in; reduce_ff <= reduce_in;
      gx_ff <= gx_in; gy_ff <= gy_in; gk_ff <= gk_in; g_ff <= g_in;
      dvd_ff <= dvd_in; rem_ff <= rem_in; cnt_ff <= cnt_in; dsel_ff <= dsel_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; rcmp_ff <= rcmp_in; rst_ff <= rst_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid    = (state_ff == S_OUT);
   assign rsp_res_num  = rnum_ff;
   assign rsp_res_den  = rden_ff;
   assign rsp_cmp_true = rcmp_ff;
   assign rsp_status   = rst_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rau_pkg::ST_OK |->
         rsp_res_num == '0 && rsp_res_den == '0 && !rsp_cmp_true)
      else $error("error beat carries nonzero payload");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> g_ff != 64'd0)
      else $error("divide by zero gcd");

   a_gk_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GCD |=> gk_ff >= $past(gk_ff))
      else $error("gcd shift count went back");

endmodule

/* rtl/rational_arithmetic_unit.sv */
// Errors and unused codes skip the arithmetic; compares cross-multiply
// only, while negate, multiply, divide, add and subtract are also reduced.
// One item is worked at a time through the binary gcd (one step a cycle)
// and the restoring divider, used twice or four times.
// A two-deep queue takes new beats while the back end is busy.
// Reset is synchronous and clears the queue and the sequencer.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact fraction add, subtract, multiply, divide, negate and compare.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic               rsp_cmp_true,
   output logic [1:0]         rsp_status
);

   rau_pkg::rau_item_type push_item, pop_item;
   logic push, full, pop, not_empty;

   rau_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .q_full    (full),
      .q_push    (push),
      .q_item    (push_item)
   );

   rau_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (pop_item),
      .not_empty (not_empty)
   );

   rau_core u_core (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (not_empty),
      .q_item       (pop_item),
      .q_pop        (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_cmp_true (rsp_cmp_true),
      .rsp_status   (rsp_status)
   );

endmodule
